@@ hw/rtl/ettr_pkg.sv @@
// Shared types, register map and constants of the auto-exposure search core.
// No dependencies; every other file refers to it by scoped names.
package ettr_pkg;

   // Field widths fixed by the register map and result format
   localparam int EXP_W     = 20;
   localparam int LVL_W     = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 20;

   // Fixed-point form of the 0.0001 fraction: count * 10000 against total
   localparam int          RATIO_W = 14;
   localparam logic [13:0] RATIO   = 14'd10000;

   // Parameter defaults
   localparam int MAX_FRAME_PIXELS_DEFAULT = 4194304;
   localparam int PIXEL_BITS_DEFAULT       = 12;

   // Depth of the frame queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_EXPOSURE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EXPOSURE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_FULL_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOWN_LEVEL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_PIXEL_LEVEL  = 3'd4;

   // Register reset values
   localparam logic [EXP_W-1:0] INITIAL_EXPOSURE_RESET = 20'd1000;
   localparam logic [EXP_W-1:0] MAX_EXPOSURE_RESET     = 20'd1004400;
   localparam logic [LVL_W-1:0] NEAR_FULL_LEVEL_RESET  = 12'd3891;
   localparam logic [LVL_W-1:0] BLOWN_LEVEL_RESET      = 12'd4055;
   localparam logic [LVL_W-1:0] HOT_PIXEL_LEVEL_RESET  = 12'd4095;

   // Frame verdict codes
   typedef enum logic [1:0] {
      VERDICT_GOOD  = 2'd0,
      VERDICT_UNDER = 2'd1,
      VERDICT_OVER  = 2'd2
   } verdict_type;

   // Configuration as seen by front and back
   typedef struct packed {
      logic [EXP_W-1:0] initial_exposure;
      logic [EXP_W-1:0] max_exposure;
      logic [LVL_W-1:0] near_full_level;
      logic [LVL_W-1:0] blown_level;
      logic [LVL_W-1:0] hot_pixel_level;
   } csr_type;

   // Width of a counter that saturates at max_pixels
   function automatic int cnt_width(input int max_pixels);
      return $clog2(max_pixels + 1);
   endfunction

endpackage

@@ hw/rtl/ettr_front.sv @@
// Front end: accepts pixels, classifies them against the levels and keeps
// the per-frame counts; pushes one queue word per frame end or restart. Uses ettr_pkg.
module ettr_front #(
   parameter int MAX_FRAME_PIXELS = ettr_pkg::MAX_FRAME_PIXELS_DEFAULT,
   parameter int PIXEL_BITS       = ettr_pkg::PIXEL_BITS_DEFAULT,
   parameter int CNT_W            = ettr_pkg::cnt_width(MAX_FRAME_PIXELS),
   parameter int DATA_W           = 3 * CNT_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   input  logic                  req_frame_end,
   input  logic                  req_restart,
   input  ettr_pkg::csr_type     csr,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [DATA_W-1:0]     push_data
);

   localparam int CMP_W = (PIXEL_BITS > ettr_pkg::LVL_W) ? PIXEL_BITS : ettr_pkg::LVL_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_PIXELS);

   logic [CNT_W-1:0] pixel_count_ff, pixel_count_in, pixel_count_inc;
   logic [CNT_W-1:0] near_count_ff, near_count_in, near_count_upd;
   logic [CNT_W-1:0] blown_count_ff, blown_count_in, blown_count_upd;
   logic [CMP_W-1:0] px;
   logic             below_hot, is_near, is_blown, accept;

   // Classify the pixel; hot pixels only count toward the total
   always_comb begin
      px        = CMP_W'(req_pixel);
      below_hot = px < CMP_W'(csr.hot_pixel_level);
      is_near   = below_hot && (px >= CMP_W'(csr.near_full_level));
      is_blown  = below_hot && (px >= CMP_W'(csr.blown_level));
   end

   // Saturating counts including the word on the port
   always_comb begin
      pixel_count_inc = (pixel_count_ff < CNT_MAX) ? pixel_count_ff + 1'b1 : pixel_count_ff;
      near_count_upd  = near_count_ff;
      blown_count_upd = blown_count_ff;
      if (is_near && near_count_ff < CNT_MAX) begin
         near_count_upd = near_count_ff + 1'b1;
      end
      if (is_blown && blown_count_ff < CNT_MAX) begin
         blown_count_upd = blown_count_ff + 1'b1;
      end
   end

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid && (req_frame_end || req_restart);
   assign push_data  = {req_restart, pixel_count_inc, near_count_upd, blown_count_upd};

   // Advance the counts, drop them at frame end or restart
   always_comb begin
      pixel_count_in = pixel_count_ff;
      near_count_in  = near_count_ff;
      blown_count_in = blown_count_ff;
      if (accept) begin
         if (req_restart || req_frame_end) begin
            pixel_count_in = '0;
            near_count_in  = '0;
            blown_count_in = '0;
         end else begin
            pixel_count_in = pixel_count_inc;
            near_count_in  = near_count_upd;
            blown_count_in = blown_count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= '0;
         near_count_ff  <= '0;
         blown_count_ff <= '0;
      end else begin
         pixel_count_ff <= pixel_count_in;
         near_count_ff  <= near_count_in;
         blown_count_ff <= blown_count_in;
      end
   end

endmodule

@@ hw/rtl/ettr_queue.sv @@
// Short register queue of frame words between front and back.
// Depth from ettr_pkg::QUEUE_DEPTH.
module ettr_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = ettr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/ettr_back.sv @@
// Back end: judges each frame (scale, compare) and steps the exposure search,
// holding the result in an output register. Uses ettr_pkg.
module ettr_back #(
   parameter int MAX_FRAME_PIXELS = ettr_pkg::MAX_FRAME_PIXELS_DEFAULT,
   parameter int CNT_W            = ettr_pkg::cnt_width(MAX_FRAME_PIXELS),
   parameter int DATA_W           = 3 * CNT_W + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  logic [DATA_W-1:0]          pop_data,
   input  ettr_pkg::csr_type          csr,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ettr_pkg::EXP_W-1:0] rsp_next_exposure,
   output logic [1:0]                 rsp_verdict,
   output logic                       rsp_search_done,
   output logic                       rsp_at_limit
);

   localparam int EXP_W  = ettr_pkg::EXP_W;
   localparam int PROD_W = CNT_W + ettr_pkg::RATIO_W;

   // Pipeline registers
   logic                      s1_valid_ff, s1_restart_ff;
   logic [CNT_W-1:0]          s1_pixel_count_ff;
   logic [PROD_W-1:0]         s1_near_prod_ff, s1_blown_prod_ff;
   logic                      s2_valid_ff, s2_restart_ff;
   ettr_pkg::verdict_type     s2_verdict_ff, s2_verdict_in;

   // Search state
   logic [EXP_W-1:0]          cur_exp_ff, under_value_ff, over_value_ff;
   logic                      under_known_ff, over_known_ff, finished_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic [EXP_W-1:0]          rsp_next_exposure_ff;
   ettr_pkg::verdict_type     rsp_verdict_ff;
   logic                      rsp_search_done_ff, rsp_at_limit_ff;

   logic                      adv, step;
   logic [CNT_W-1:0]          in_pixel_count, in_near_count, in_blown_count;
   logic [EXP_W:0]            under_sum, over_sum, doubled, max_ext, cur_ext;
   logic                      at_max, done;
   logic                      limit;
   logic [EXP_W-1:0]          next_exp;

   // Whole back end moves together unless a result waits
   assign adv       = !(rsp_valid_ff && !rsp_ready);
   assign pop_ready = adv;
   assign step      = adv && s2_valid_ff && !s2_restart_ff;

   assign in_blown_count = pop_data[CNT_W-1:0];
   assign in_near_count  = pop_data[2*CNT_W-1:CNT_W];
   assign in_pixel_count = pop_data[3*CNT_W-1:2*CNT_W];

   // Stage 1: scale the near-full and blown counts
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_restart_ff     <= pop_data[DATA_W-1];
         s1_pixel_count_ff <= in_pixel_count;
         s1_near_prod_ff   <= PROD_W'(in_near_count) * PROD_W'(ettr_pkg::RATIO);
         s1_blown_prod_ff  <= PROD_W'(in_blown_count) * PROD_W'(ettr_pkg::RATIO);
      end
   end

   // Stage 2: judge the frame
   always_comb begin
      if (s1_near_prod_ff < PROD_W'(s1_pixel_count_ff)) begin
         s2_verdict_in = ettr_pkg::VERDICT_UNDER;
      end else if (s1_blown_prod_ff > PROD_W'(s1_pixel_count_ff)) begin
         s2_verdict_in = ettr_pkg::VERDICT_OVER;
      end else begin
         s2_verdict_in = ettr_pkg::VERDICT_GOOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_restart_ff <= s1_restart_ff;
         s2_verdict_ff <= s2_verdict_in;
      end
   end

   // Stage 3: candidate exposures
   always_comb begin
      cur_ext   = {1'b0, cur_exp_ff};
      max_ext   = {1'b0, csr.max_exposure};
      under_sum = cur_ext + {1'b0, under_value_ff};
      over_sum  = cur_ext + {1'b0, over_value_ff};
      doubled   = {cur_exp_ff, 1'b0};
      at_max    = (cur_ext + 1'b1 >= max_ext) && (cur_ext <= max_ext + 1'b1);
   end

   // Bisect, halve or double; stop on a good frame, at the limit or on no change
   always_comb begin
      next_exp = cur_exp_ff;
      done     = 1'b0;
      limit    = 1'b0;
      if (finished_ff || s2_verdict_ff == ettr_pkg::VERDICT_GOOD) begin
         done = 1'b1;
      end else if (s2_verdict_ff == ettr_pkg::VERDICT_OVER) begin
         next_exp = under_known_ff ? under_sum[EXP_W:1] : cur_exp_ff >> 1;
      end else if (over_known_ff) begin
         next_exp = over_sum[EXP_W:1];
      end else if (at_max) begin
         limit = 1'b1;
         done  = 1'b1;
      end else begin
         next_exp = (doubled < max_ext) ? doubled[EXP_W-1:0] : csr.max_exposure;
      end
      if (!done && next_exp == cur_exp_ff) begin
         done = 1'b1;
         if (s2_verdict_ff == ettr_pkg::VERDICT_OVER && under_known_ff) begin
            next_exp = under_value_ff;
         end
      end
   end

   // Update search state; restart reloads the initial exposure
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_exp_ff     <= ettr_pkg::INITIAL_EXPOSURE_RESET;
         under_known_ff <= 1'b0;
         over_known_ff  <= 1'b0;
         finished_ff    <= 1'b0;
      end else if (adv && s2_valid_ff && s2_restart_ff) begin
         cur_exp_ff     <= csr.initial_exposure;
         under_known_ff <= 1'b0;
         over_known_ff  <= 1'b0;
         finished_ff    <= 1'b0;
      end else if (step && !finished_ff && s2_verdict_ff != ettr_pkg::VERDICT_GOOD) begin
         cur_exp_ff  <= next_exp;
         finished_ff <= done;
         if (s2_verdict_ff == ettr_pkg::VERDICT_OVER) begin
            over_known_ff <= 1'b1;
         end else begin
            under_known_ff <= 1'b1;
         end
      end
   end

   // Last under- and overexposed values
   always_ff @(posedge clock) begin
      if (step && !finished_ff && s2_verdict_ff == ettr_pkg::VERDICT_OVER) begin
         over_value_ff <= cur_exp_ff;
      end
      if (step && !finished_ff && s2_verdict_ff == ettr_pkg::VERDICT_UNDER) begin
         under_value_ff <= cur_exp_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff && !s2_restart_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_next_exposure_ff <= next_exp;
         rsp_verdict_ff       <= s2_verdict_ff;
         rsp_search_done_ff   <= done;
         rsp_at_limit_ff      <= limit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_exposure = rsp_next_exposure_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_search_done   = rsp_search_done_ff;
   assign rsp_at_limit      = rsp_at_limit_ff;

endmodule

@@ hw/rtl/ettr_auto_exposure_search_core.sv @@
// Channel   Ports                                          Moves
// req       req_valid/ready, pixel, frame_end, restart     one pixel word per cycle while ready
// rsp       rsp_valid/ready, next_exposure, verdict, ...   one result word per frame end
// csr       csr_wen, csr_index, csr_wdata                  register write, no wait
//
// Takes one pixel word per cycle while req_ready is high; per-pixel work is compares
// and counter steps. rsp_valid rises once a frame's last pixel has passed the queue
// write, scale, judge and search step into the output register; the four-entry frame
// queue lets frames follow back to back.
// Reset is synchronous; there is no clearing pass.
// A stalled rsp freezes the back end; req_ready drops only once the queue is full.
// Top level: register file plus front, queue and back. Uses ettr_pkg.
module ettr_auto_exposure_search_core #(
   parameter int MAX_FRAME_PIXELS = ettr_pkg::MAX_FRAME_PIXELS_DEFAULT,
   parameter int PIXEL_BITS       = ettr_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [PIXEL_BITS-1:0]          req_pixel,
   input  logic                           req_frame_end,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ettr_pkg::EXP_W-1:0]     rsp_next_exposure,
   output logic [1:0]                     rsp_verdict,
   output logic                           rsp_search_done,
   output logic                           rsp_at_limit,
   input  logic                           csr_wen,
   input  logic [ettr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ettr_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int CNT_W  = ettr_pkg::cnt_width(MAX_FRAME_PIXELS);
   localparam int DATA_W = 3 * CNT_W + 1;

   ettr_pkg::csr_type csr_ff;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   logic [DATA_W-1:0] push_data, pop_data;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.initial_exposure <= ettr_pkg::INITIAL_EXPOSURE_RESET;
         csr_ff.max_exposure     <= ettr_pkg::MAX_EXPOSURE_RESET;
         csr_ff.near_full_level  <= ettr_pkg::NEAR_FULL_LEVEL_RESET;
         csr_ff.blown_level      <= ettr_pkg::BLOWN_LEVEL_RESET;
         csr_ff.hot_pixel_level  <= ettr_pkg::HOT_PIXEL_LEVEL_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            ettr_pkg::CSR_INITIAL_EXPOSURE: begin
               csr_ff.initial_exposure <= csr_wdata[ettr_pkg::EXP_W-1:0];
            end
            ettr_pkg::CSR_MAX_EXPOSURE: begin
               csr_ff.max_exposure <= csr_wdata[ettr_pkg::EXP_W-1:0];
            end
            ettr_pkg::CSR_NEAR_FULL_LEVEL: begin
               csr_ff.near_full_level <= csr_wdata[ettr_pkg::LVL_W-1:0];
            end
            ettr_pkg::CSR_BLOWN_LEVEL: begin
               csr_ff.blown_level <= csr_wdata[ettr_pkg::LVL_W-1:0];
            end
            ettr_pkg::CSR_HOT_PIXEL_LEVEL: begin
               csr_ff.hot_pixel_level <= csr_wdata[ettr_pkg::LVL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   ettr_front #(
      .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
      .PIXEL_BITS       (PIXEL_BITS),
      .CNT_W            (CNT_W),
      .DATA_W           (DATA_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .req_frame_end (req_frame_end),
      .req_restart   (req_restart),
      .csr           (csr_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   ettr_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ettr_back #(
      .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
      .CNT_W            (CNT_W),
      .DATA_W           (DATA_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .csr               (csr_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_exposure (rsp_next_exposure),
      .rsp_verdict       (rsp_verdict),
      .rsp_search_done   (rsp_search_done),
      .rsp_at_limit      (rsp_at_limit)
   );

endmodule

@@ hw/rtl/ettr_checker.sv @@
// Port-level checks on the result channel of the search core.
// Uses ettr_pkg; bound to ettr_auto_exposure_search_core below.
module ettr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ettr_pkg::EXP_W-1:0] rsp_next_exposure,
   input logic [1:0]                 rsp_verdict,
   input logic                       rsp_search_done,
   input logic                       rsp_at_limit
);

   // A waiting word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_exposure)
         && $stable(rsp_verdict) && $stable(rsp_search_done) && $stable(rsp_at_limit))
      else $error("rsp word changed while stalled");

   // No result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A good frame always ends the search
   a_good_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == ettr_pkg::VERDICT_GOOD |-> rsp_search_done)
      else $error("good frame without search done");

   // The limit flag comes only with an underexposed, finished search
   a_limit_under: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_limit |-> rsp_search_done
         && rsp_verdict == ettr_pkg::VERDICT_UNDER)
      else $error("at limit without underexposed done");

   // Verdict is one of the three codes
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict == ettr_pkg::VERDICT_GOOD
         || rsp_verdict == ettr_pkg::VERDICT_UNDER || rsp_verdict == ettr_pkg::VERDICT_OVER)
      else $error("verdict code out of range");

endmodule

bind ettr_auto_exposure_search_core ettr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_next_exposure (rsp_next_exposure),
   .rsp_verdict       (rsp_verdict),
   .rsp_search_done   (rsp_search_done),
   .rsp_at_limit      (rsp_at_limit)
);
